// ===== sv/nmf_pkg.sv =====
// Shared types, constants and sorting-network helpers for the neighbour median filter.
`timescale 1ns / 1ps

package nmf_pkg;

   // Pixel channel width.
   localparam int PIXEL_W = 8;

   // Smallest frame dimension that the filter accepts.
   localparam int MIN_DIM = 3;

   // Register values after reset.
   localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd480;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Input beat kinds.
   typedef enum logic [0:0] {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // One window column: element 0 is the oldest row, element 2 the current row.
   typedef pixel_type [2:0] column_type;

   // The eight neighbours of the centre pixel.
   typedef pixel_type [7:0] nbr_vec_type;

   // Side information that travels with a window through the sorter.
   typedef struct packed {
      logic      border;
      logic      last;
      pixel_type centre;
   } item_meta_type;

   // Order one pair so that the lower index holds the smaller value.
   function automatic nbr_vec_type cmp_swap(input nbr_vec_type v, input logic [2:0] lo,
                                            input logic [2:0] hi);
      nbr_vec_type r;
      r = v;
      if (v[lo] > v[hi]) begin
         r[lo] = v[hi];
         r[hi] = v[lo];
      end
      return r;
   endfunction

   // One layer of the odd-even merge sorting network for eight values.
   function automatic nbr_vec_type sort_layer(input nbr_vec_type v, input logic [2:0] layer);
      nbr_vec_type r;
      r = v;
      case (layer)
         3'd0: begin
            r = cmp_swap(r, 3'd0, 3'd1);
            r = cmp_swap(r, 3'd2, 3'd3);
            r = cmp_swap(r, 3'd4, 3'd5);
            r = cmp_swap(r, 3'd6, 3'd7);
         end
         3'd1: begin
            r = cmp_swap(r, 3'd0, 3'd2);
            r = cmp_swap(r, 3'd1, 3'd3);
            r = cmp_swap(r, 3'd4, 3'd6);
            r = cmp_swap(r, 3'd5, 3'd7);
         end
         3'd2: begin
            r = cmp_swap(r, 3'd1, 3'd2);
            r = cmp_swap(r, 3'd5, 3'd6);
         end
         3'd3: begin
            r = cmp_swap(r, 3'd0, 3'd4);
            r = cmp_swap(r, 3'd1, 3'd5);
            r = cmp_swap(r, 3'd2, 3'd6);
            r = cmp_swap(r, 3'd3, 3'd7);
         end
         3'd4: begin
            r = cmp_swap(r, 3'd2, 3'd4);
            r = cmp_swap(r, 3'd3, 3'd5);
         end
         3'd5: begin
            r = cmp_swap(r, 3'd1, 3'd2);
            r = cmp_swap(r, 3'd3, 3'd4);
            r = cmp_swap(r, 3'd5, 3'd6);
         end
         default: begin
            r = v;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== sv/nmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module nmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds while the port is not enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/nmf_column_cell.sv =====
// One column of the 3x3 window; hands its column to the next cell on each shift.
`timescale 1ns / 1ps

module nmf_column_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift_en,
   input  nmf_pkg::column_type col_in,
   output nmf_pkg::column_type col_q
);
   import nmf_pkg::*;

   column_type col_ff;
   column_type col_in_sel;

   // Load the neighbor's column on a shift, otherwise hold.
   always_comb begin
      col_in_sel = shift_en ? col_in : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_sel;
      end
   end

   assign col_q = col_ff;

endmodule

// ===== sv/nmf_sort_stage.sv =====
// Two layers of the eight-input sorting network followed by a pipeline register.
`timescale 1ns / 1ps

module nmf_sort_stage #(
   parameter int FIRST_LAYER = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  nmf_pkg::nbr_vec_type  in_vec,
   input  nmf_pkg::item_meta_type in_meta,
   output logic                  out_valid,
   input  logic                  out_ready,
   output nmf_pkg::nbr_vec_type  out_vec,
   output nmf_pkg::item_meta_type out_meta
);
   import nmf_pkg::*;

   logic          valid_ff;
   nbr_vec_type   vec_ff;
   nbr_vec_type   vec_in;
   item_meta_type meta_ff;
   logic          load_en;

   // The stage takes a new beat when it is empty or its beat moves on.
   assign load_en  = !valid_ff || out_ready;
   assign in_ready = load_en;

   // Compare-exchange layers of this stage.
   always_comb begin
      vec_in = sort_layer(sort_layer(in_vec, 3'(FIRST_LAYER)), 3'(FIRST_LAYER + 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en && in_valid) begin
         vec_ff  <= vec_in;
         meta_ff <= in_meta;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_meta  = meta_ff;

endmodule

// ===== sv/neighbour_median_image_filter_core.sv =====
// Top level of the streaming 3x3 neighbour median filter.
`timescale 1ns / 1ps

// Streaming 3x3 neighbour median filter for one 8-bit channel. Pixel beats (op 0) arrive in
// row order; every interior pixel is replaced by the 4th smallest of its eight neighbours,
// border pixels pass through. The block takes one beat per clock while the result channel does
// not stall: each beat reads its column of the line store on the accept edge and writes it back
// as it moves from the line-store stage register into the window. The line store has separate
// read and write ports, so one beat's read shares a cycle with the previous beat's write-back.
// A result passes the window stage and the sorter stages into the output register; in beats, a
// result lags its pixel by one row plus one pixel, so after the last pixel of a frame width+1
// drain beats (op 1) flush the rest, the final one flagged with frame_last. Pixel beats after
// the frame is complete and drain beats while pixels are still expected are accepted and
// dropped. Any register write restarts the frame. The line store needs no clearing pass
// after reset.
module neighbour_median_image_filter_core #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   // Pixel input channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_pixel_in,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_out,
   output logic        rsp_frame_last,
   // Configuration write port.
   input  logic        csr_write_en,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import nmf_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int UW = (AW + 1 > 12) ? AW + 1 : 12;
   localparam int RW = 17;

   // Configuration registers.
   logic [11:0] frame_width_ff;
   logic [15:0] frame_height_ff;

   // Frame position of the next beat.
   logic [AW-1:0] col_ff;
   logic [AW-1:0] col_in;
   logic [RW-1:0] row_ff;
   logic [RW-1:0] row_in;

   // Width and height in use.
   logic [UW-1:0] fw_ext;
   logic [AW:0]   w_use;
   logic [15:0]   h_use;
   logic [RW-1:0] h_row;
   logic [RW-1:0] h_last;

   // Per-beat decode.
   logic          accept;
   logic          is_drain;
   logic          proceed;
   logic          take;
   logic [AW:0]   col_inc;
   logic          col_zero;
   logic          row_one;
   logic          emit;
   logic          border;
   logic          last;

   // Line-store stage.
   logic            s1_valid_ff;
   logic [AW-1:0]   s1_col_ff;
   pixel_type       s1_pixel_ff;
   logic            s1_emit_ff;
   logic            s1_border_ff;
   logic            s1_last_ff;
   logic            s1_move;
   logic            s1_load_en;
   logic [2*PIXEL_W-1:0] store_rd_data;
   logic [2*PIXEL_W-1:0] store_wr_data;

   // Window stage.
   logic            s2_valid_ff;
   logic            s2_border_ff;
   logic            s2_last_ff;
   logic            s2_load_en;
   column_type      new_col;
   column_type      col_q0;
   column_type      col_q1;
   column_type      col_q2;
   nbr_vec_type     nbr_vec;
   item_meta_type   s2_meta;

   // Sorter stages.
   logic            st_ready  [3];
   logic            st_valid  [3];
   nbr_vec_type     st_vec    [3];
   item_meta_type   st_meta   [3];

   // Clamp the configured dimensions.
   always_comb begin
      fw_ext = UW'(frame_width_ff);
      if (fw_ext < UW'(MIN_DIM)) begin
         w_use = (AW + 1)'(MIN_DIM);
      end else if (fw_ext > UW'(MAX_WIDTH)) begin
         w_use = (AW + 1)'(MAX_WIDTH);
      end else begin
         w_use = fw_ext[AW:0];
      end
      h_use  = (frame_height_ff < 16'(MIN_DIM)) ? 16'(MIN_DIM) : frame_height_ff;
      h_row  = {1'b0, h_use};
      h_last = h_row + RW'(1);
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[11:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Handshake and beat decode.
   assign req_ready = s1_load_en;
   assign accept    = req_valid && req_ready;

   always_comb begin
      is_drain = (op_type'(req_op) == OP_DRAIN);
      proceed  = is_drain ? (row_ff >= h_row) : (row_ff < h_row);
      take     = accept && proceed;
      col_inc  = {1'b0, col_ff} + (AW + 1)'(1);
      col_zero = (col_ff == '0);
      row_one  = (row_ff == RW'(1));
      emit     = (row_ff >= RW'(2)) || (row_one && !col_zero);
      border   = col_zero || (col_ff == AW'(1)) || row_one || (row_ff == h_row);
      last     = col_zero && (row_ff == h_last);
   end

   // Position counters.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc == w_use) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_inc[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (csr_write_en) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line store: upper row in the high byte, middle row in the low byte.
   assign store_wr_data = {store_rd_data[PIXEL_W-1:0], s1_pixel_ff};

   nmf_ram #(
      .WIDTH (2 * PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (store_wr_data),
      .rd_en   (take),
      .rd_addr (col_ff),
      .rd_data (store_rd_data)
   );

   // Line-store stage register.
   assign s1_move    = s1_valid_ff && s2_load_en;
   assign s1_load_en = !s1_valid_ff || s2_load_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load_en) begin
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_col_ff    <= col_ff;
         s1_pixel_ff  <= is_drain ? '0 : req_pixel_in;
         s1_emit_ff   <= emit;
         s1_border_ff <= border;
         s1_last_ff   <= last;
      end
   end

   // Window: the new column enters the newest cell and shifts toward the oldest.
   always_comb begin
      new_col[0] = store_rd_data[2*PIXEL_W-1:PIXEL_W];
      new_col[1] = store_rd_data[PIXEL_W-1:0];
      new_col[2] = s1_pixel_ff;
   end

   nmf_column_cell u_col2 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_move),
      .col_in   (new_col),
      .col_q    (col_q2)
   );

   nmf_column_cell u_col1 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_move),
      .col_in   (col_q2),
      .col_q    (col_q1)
   );

   nmf_column_cell u_col0 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_move),
      .col_in   (col_q1),
      .col_q    (col_q0)
   );

   // Window stage: only beats that produce a result go on to the sorter.
   assign s2_load_en = !s2_valid_ff || st_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load_en) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_border_ff <= s1_border_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   // Gather the eight neighbours, leaving out the centre.
   always_comb begin
      nbr_vec[0]     = col_q0[0];
      nbr_vec[1]     = col_q1[0];
      nbr_vec[2]     = col_q2[0];
      nbr_vec[3]     = col_q0[1];
      nbr_vec[4]     = col_q2[1];
      nbr_vec[5]     = col_q0[2];
      nbr_vec[6]     = col_q1[2];
      nbr_vec[7]     = col_q2[2];
      s2_meta.border = s2_border_ff;
      s2_meta.last   = s2_last_ff;
      s2_meta.centre = col_q1[1];
   end

   // Sorting network, two layers per stage.
   nmf_sort_stage #(
      .FIRST_LAYER (0)
   ) u_sort0 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_ready  (st_ready[0]),
      .in_vec    (nbr_vec),
      .in_meta   (s2_meta),
      .out_valid (st_valid[0]),
      .out_ready (st_ready[1]),
      .out_vec   (st_vec[0]),
      .out_meta  (st_meta[0])
   );

   nmf_sort_stage #(
      .FIRST_LAYER (2)
   ) u_sort1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_valid[0]),
      .in_ready  (st_ready[1]),
      .in_vec    (st_vec[0]),
      .in_meta   (st_meta[0]),
      .out_valid (st_valid[1]),
      .out_ready (st_ready[2]),
      .out_vec   (st_vec[1]),
      .out_meta  (st_meta[1])
   );

   nmf_sort_stage #(
      .FIRST_LAYER (4)
   ) u_sort2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_valid[1]),
      .in_ready  (st_ready[2]),
      .in_vec    (st_vec[1]),
      .in_meta   (st_meta[1]),
      .out_valid (st_valid[2]),
      .out_ready (rsp_ready),
      .out_vec   (st_vec[2]),
      .out_meta  (st_meta[2])
   );

   // The last sorter register is the output register.
   assign rsp_valid      = st_valid[2];
   assign rsp_pixel_out  = st_meta[2].border ? st_meta[2].centre : st_vec[2][3];
   assign rsp_frame_last = st_meta[2].last;

`ifndef SYNTHESIS
   // The column position always stays inside the row in use.
   assert property (@(posedge clock) disable iff (reset) {1'b0, col_ff} < w_use)
      else $error("column position reached the row width");

   // The row position never passes the drain row of the frame.
   assert property (@(posedge clock) disable iff (reset) row_ff <= h_last)
      else $error("row position ran past the end of the frame");

   // Input stalls only when every stage is full and the output beat is held.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && s1_valid_ff && s2_valid_ff))
      else $error("input stalled while the pipeline had room");
`endif

endmodule
